/* sv/rope_pkg.sv */
// shared types, constants and tables for the rotary position embedding block
package rope_pkg;

  localparam int HalfDimDefault     = 64;
  localparam int CordicStepsDefault = 16;
  localparam int MaxCordic          = 24;
  localparam logic [15:0] ScaleGainReset    = 16'd16384;
  localparam logic [15:0] MaxPositionsReset = 16'd2048;
  localparam logic signed [33:0] InvGainQ30 = 34'sd652032874;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ROTATE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  localparam logic CFG_SCALE_GAIN    = 1'b0;
  localparam logic CFG_MAX_POSITIONS = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         pair_index;
    logic [15:0]        seq_offset;
    logic signed [15:0] x_first;
    logic signed [15:0] x_second;
    logic [31:0]        step_value;
    logic [15:0]        advance_count;
  } rope_in_t;

  typedef struct packed {
    logic signed [15:0] y_first;
    logic signed [15:0] y_second;
    logic [15:0]        position_now;
  } rope_out_t;

  // payload carried along the cordic row
  typedef struct packed {
    logic signed [15:0] x_first;
    logic signed [15:0] x_second;
    logic [15:0]        position_now;
    logic               rotate;
    logic               flip;
  } rope_tag_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } rope_vec_t;

  function automatic logic signed [33:0] atan_turns(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/rotary_position_embedding.sv */
// top level of the rotary position embedding block
// an input beat passes front stages a and b, the cordic cells, then back stages g and m and the output register
// throughput: one beat per cycle, set by the row of cordic cells, one
// micro-rotation per cell
// the whole pipeline advances together and holds while the output is stalled
// synchronous active-low reset clears valids, position counter and config registers;
// step table contents are undefined until loaded
module rotary_position_embedding #(
  parameter int HALF_DIM     = rope_pkg::HalfDimDefault,
  parameter int CORDIC_STEPS = rope_pkg::CordicStepsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rope_pkg::rope_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rope_pkg::rope_out_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import rope_pkg::*;

  logic [15:0] scale_gain_r, max_positions_r;
  logic        en, in_fire;

  // global enable: advance unless the last stage holds an untaken beat
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_gain_r    <= ScaleGainReset;
      max_positions_r <= MaxPositionsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_GAIN:    scale_gain_r    <= cfg_wdata;
        CFG_MAX_POSITIONS: max_positions_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row of cordic cells, slot 0 is the front end output
  logic      v   [CORDIC_STEPS+1];
  rope_vec_t vec [CORDIC_STEPS+1];
  rope_tag_t tag [CORDIC_STEPS+1];

  rope_front #(.HalfDim(HALF_DIM)) u_front (
    .clk, .rst_n, .en, .in_fire, .in_data,
    .max_positions(max_positions_r),
    .out_valid(v[0]), .out_vec(vec[0]), .out_tag(tag[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    rope_cell #(.Shift(i)) u_cell (
      .clk, .rst_n, .en,
      .in_valid(v[i]), .in_vec(vec[i]), .in_tag(tag[i]),
      .out_valid(v[i+1]), .out_vec(vec[i+1]), .out_tag(tag[i+1])
    );
  end

  rope_back u_back (
    .clk, .rst_n, .en,
    .in_valid(v[CORDIC_STEPS]), .in_vec(vec[CORDIC_STEPS]), .in_tag(tag[CORDIC_STEPS]),
    .scale_gain(scale_gain_r),
    .out_valid, .out_data
  );

  // a stalled output beat keeps its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output changed while stalled");
  // ready follows the output stall exactly
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready mismatch");
  // an offered output beat carries fully known data
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("unknown output data");

endmodule

/* sv/rope_cell.sv */
// one cordic micro-rotation cell with its pipeline register
module rope_cell #(
  parameter int Shift = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rope_pkg::rope_vec_t in_vec,
  input  rope_pkg::rope_tag_t in_tag,
  output logic                out_valid,
  output rope_pkg::rope_vec_t out_vec,
  output rope_pkg::rope_tag_t out_tag
);
  import rope_pkg::*;

  rope_vec_t vec_nxt;
  logic signed [33:0] xs, ys, at;

  always_comb begin
    xs = in_vec.x >>> Shift;
    ys = in_vec.y >>> Shift;
    at = atan_turns(Shift);
    if (!in_vec.z[33]) begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - at;
    end else begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_vec <= vec_nxt;
      out_tag <= in_tag;
    end
  end

endmodule

/* sv/rope_front.sv */
// step table, position counter, angle multiply and quadrant fold
module rope_front #(
  parameter int HalfDim = rope_pkg::HalfDimDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_fire,
  input  rope_pkg::rope_in_t  in_data,
  input  logic [15:0]         max_positions,
  output logic                out_valid,
  output rope_pkg::rope_vec_t out_vec,
  output rope_pkg::rope_tag_t out_tag
);
  import rope_pkg::*;

  // the 6-bit pair index reaches at most 64 entries
  localparam int TableDepth = (HalfDim < 64) ? HalfDim : 64;
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  logic [31:0] step_mem [TableDepth];
  logic [15:0] position_r, position_nxt;

  // stage a: table read, position sum
  logic        a_valid_r;
  logic [31:0] a_step_r;
  logic [16:0] a_pos_r;
  logic        a_idx_ok_r;
  rope_tag_t   a_tag_r;
  // stage b: angle product
  logic        b_valid_r;
  logic [31:0] b_ang_r;
  rope_tag_t   b_tag_r;

  logic        idx_ok;
  logic [16:0] adv_sum;
  logic [31:0] step_use;
  logic [48:0] prod;
  logic [31:0] ang_f;
  logic        fl;
  rope_tag_t   tag_in;

  assign idx_ok  = ({26'd0, in_data.pair_index} < 32'(HalfDim));
  assign adv_sum = {1'b0, position_r} + {1'b0, in_data.advance_count};

  always_comb begin
    position_nxt = position_r;
    if (in_fire && in_data.opcode == OP_ADVANCE) begin
      position_nxt = (adv_sum >= {1'b0, max_positions}) ? 16'd0 : adv_sum[15:0];
    end
    tag_in.x_first      = in_data.x_first;
    tag_in.x_second     = in_data.x_second;
    tag_in.position_now = position_nxt;
    tag_in.rotate       = (in_data.opcode == OP_ROTATE);
    tag_in.flip         = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.opcode == OP_LOAD && idx_ok) begin
      step_mem[in_data.pair_index[IdxW-1:0]] <= in_data.step_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
    end else begin
      position_r <= position_nxt;
      if (en) begin
        a_valid_r <= in_fire;
        b_valid_r <= a_valid_r;
      end
    end
    if (en) begin
      a_step_r   <= step_mem[in_data.pair_index[IdxW-1:0]];
      a_idx_ok_r <= idx_ok;
      a_pos_r    <= {1'b0, position_r} + {1'b0, in_data.seq_offset};
      a_tag_r    <= tag_in;
      b_ang_r    <= prod[31:0];
      b_tag_r    <= a_tag_r;
    end
  end

  assign step_use = a_idx_ok_r ? a_step_r : 32'd0;
  assign prod     = 49'(a_pos_r) * 49'(step_use);

  // fold quadrants 1 and 2 by a half turn and negate afterwards
  assign fl    = b_ang_r[31] ^ b_ang_r[30];
  assign ang_f = fl ? (b_ang_r - 32'h8000_0000) : b_ang_r;

  always_comb begin
    out_valid   = b_valid_r;
    out_vec.x   = InvGainQ30;
    out_vec.y   = '0;
    out_vec.z   = {{2{ang_f[31]}}, ang_f};
    out_tag     = b_tag_r;
    out_tag.flip = fl;
  end

endmodule

/* sv/rope_back.sv */
// gain scaling, rotation of the pair, rounding and saturation
module rope_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rope_pkg::rope_vec_t in_vec,
  input  rope_pkg::rope_tag_t in_tag,
  input  logic [15:0]         scale_gain,
  output logic                out_valid,
  output rope_pkg::rope_out_t out_data
);
  import rope_pkg::*;

  // stage g: gain
  logic               g_valid_r;
  logic signed [33:0] g_c_r, g_s_r;
  rope_tag_t          g_tag_r;
  // stage m: four products
  logic               m_valid_r;
  logic signed [49:0] m_xc1_r, m_xs1_r, m_xc2_r, m_xs2_r;
  rope_tag_t          m_tag_r;

  logic signed [33:0] cr, sr;
  logic signed [50:0] cg, sg;
  logic signed [51:0] sf, ss;
  logic signed [21:0] hf, hs;
  rope_out_t          res;

  assign cr = in_tag.flip ? -in_vec.x : in_vec.x;
  assign sr = in_tag.flip ? -in_vec.y : in_vec.y;
  assign cg = (51'(cr) * $signed({1'b0, scale_gain})) + 51'sd8192;
  assign sg = (51'(sr) * $signed({1'b0, scale_gain})) + 51'sd8192;

  assign sf = 52'(m_xc1_r) - 52'(m_xs2_r) + 52'sd536870912;
  assign ss = 52'(m_xs1_r) + 52'(m_xc2_r) + 52'sd536870912;
  assign hf = sf[51:30];
  assign hs = ss[51:30];

  always_comb begin
    res.position_now = m_tag_r.position_now;
    if (!m_tag_r.rotate) res.y_first = '0;
    else if (hf > 22'sd32767) res.y_first = 16'sh7fff;
    else if (hf < -22'sd32768) res.y_first = 16'sh8000;
    else res.y_first = hf[15:0];
    if (!m_tag_r.rotate) res.y_second = '0;
    else if (hs > 22'sd32767) res.y_second = 16'sh7fff;
    else if (hs < -22'sd32768) res.y_second = 16'sh8000;
    else res.y_second = hs[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      g_valid_r <= in_valid;
      m_valid_r <= g_valid_r;
      out_valid <= m_valid_r;
    end
    if (en) begin
      g_c_r    <= 34'(cg >>> 14);
      g_s_r    <= 34'(sg >>> 14);
      g_tag_r  <= in_tag;
      m_xc1_r  <= 50'(g_tag_r.x_first) * 50'(g_c_r);
      m_xs1_r  <= 50'(g_tag_r.x_first) * 50'(g_s_r);
      m_xc2_r  <= 50'(g_tag_r.x_second) * 50'(g_c_r);
      m_xs2_r  <= 50'(g_tag_r.x_second) * 50'(g_s_r);
      m_tag_r  <= g_tag_r;
      out_data <= res;
    end
  end

endmodule
